// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SER_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SER_ASSERT_SAME(label, ante, cons, msg)
`define SER_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/ser_pkg.sv
// ----------------------------------------------------------------------------
// ser_pkg
// Shared types and codes of the spike event router.
// ----------------------------------------------------------------------------
package ser_pkg;

    localparam int BITFIELD_WIDTH = 32;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] REG_BITFIELD = 3'd0;
    localparam logic [2:0] REG_IDBASE   = 3'd1;
    localparam logic [2:0] REG_BARRIER  = 3'd2;
    localparam logic [2:0] REG_SWAP     = 3'd3;
    localparam logic [2:0] REG_RSTART   = 3'd4;
    localparam logic [2:0] REG_REND     = 3'd5;
    localparam logic [2:0] REG_BCOUNT   = 3'd6;

    localparam logic CFG_MEM_BASE = 1'b0;
    localparam logic CFG_MEM_SIZE = 1'b1;

    localparam logic [31:0] BARRIER_WORD  = 32'hFFFF_FFFF;
    localparam logic [31:0] WORD_BYTES    = 32'd4;
    localparam logic [31:0] ADDR_MASK     = 32'hFFFF_FFFC;
    localparam logic [31:0] RST_MEM_SIZE  = 32'd4096;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  reg_index;
        logic [31:0] reg_wdata;
        logic        rx_valid;
        logic [31:0] rx_data;
        logic        tx_granted;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [31:0] tx_data;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [31:0] mem_data;
        logic [31:0] reg_rdata;
        logic        overrun;
        logic        write_dropped;
    } result_t;

    typedef struct packed {
        logic        addr;
        logic [31:0] wdata;
    } cfg_t;

endpackage

// File: src/ser_channels.sv
// ----------------------------------------------------------------------------
// ser_channels
// Valid/ready channel interfaces for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ser_item_if;
    logic           valid;
    logic           ready;
    ser_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ser_result_if;
    logic             valid;
    logic             ready;
    ser_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ser_cfg_if;
    logic          valid;
    logic          ready;
    ser_pkg::cfg_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/spike_event_router.sv
// ----------------------------------------------------------------------------
// spike_event_router
// Register-mapped router that serializes event bitfields onto a shared bus
// and stores received events in a double-buffered spike memory.
// ----------------------------------------------------------------------------
// Each transaction on items is a bus tick, a register write or a register
// read, and it produces exactly one transaction on results.
// A transaction on cfg sets the spike memory base or size and reloads the
// buffer pointers; the user must issue it only while the block is idle,
// which the block itself does not enforce. An accepted item waits in an
// input register and is evaluated into the result register once that is free.
// One item is taken every cycle while results does not stall; the rate comes
// from the router state update, which reads and writes all state in the same cycle.
// Reset clears the state machine and registers, sets the memory to base 0
// and size 4096, and publishes an empty read range at the end of memory.
// When results stalls, the result register holds its transaction, the
// input register keeps the next item, and items.ready drops until the
// result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spike_event_router (
    input logic    clk,
    input logic    rst_n,
    ser_cfg_if.sink    cfg,
    ser_item_if.sink   items,
    ser_result_if.source results
);
    import ser_pkg::*;

    localparam logic [1:0] ST_IDLE         = 2'd0;
    localparam logic [1:0] ST_EXTRACT      = 2'd1;
    localparam logic [1:0] ST_WAIT_SPIKE   = 2'd2;
    localparam logic [1:0] ST_WAIT_BARRIER = 2'd3;

    function automatic logic [5:0] trail_zeros(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    logic        item_valid_reg;
    item_t       item_reg;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, res;

    logic [31:0] mem_base_reg, mem_base_next;
    logic [31:0] mem_size_reg, mem_size_next;
    logic [1:0]  state_reg, state_next;
    logic [31:0] bitfield_reg, bitfield_next;
    logic [31:0] idbase_reg, idbase_next;
    logic [31:0] barrier_reg, barrier_next;
    logic [31:0] swap_reg, swap_next;
    logic [31:0] rstart_reg, rstart_next;
    logic [31:0] rend_reg, rend_next;
    logic [31:0] bcount_reg, bcount_next;
    logic [31:0] pending_reg, pending_next;
    logic [31:0] id_base_reg, id_base_next;
    logic [5:0]  spike_index_reg, spike_index_next;
    logic [31:0] wp_reg, wp_next;
    logic        front_reg, front_next;

    logic        advance;
    logic        process;
    logic [5:0]  tz;
    logic [31:0] end_addr;
    logic [31:0] cfg_end;

    assign advance       = !result_valid_reg || results.ready;
    assign process       = item_valid_reg && advance;
    assign items.ready   = !item_valid_reg || advance;
    assign cfg.ready     = 1'b1;
    assign results.valid = result_valid_reg;
    assign results.payload = result_reg;
    assign tz            = trail_zeros(pending_reg);
    assign end_addr      = mem_base_reg + mem_size_reg;
    assign result_valid_next = advance ? item_valid_reg : result_valid_reg;

    always_comb
    begin
        res              = '0;
        mem_base_next    = mem_base_reg;
        mem_size_next    = mem_size_reg;
        state_next       = state_reg;
        bitfield_next    = bitfield_reg;
        idbase_next      = idbase_reg;
        barrier_next     = barrier_reg;
        swap_next        = swap_reg;
        rstart_next      = rstart_reg;
        rend_next        = rend_reg;
        bcount_next      = bcount_reg;
        pending_next     = pending_reg;
        id_base_next     = id_base_reg;
        spike_index_next = spike_index_reg;
        wp_next          = wp_reg;
        front_next       = front_reg;
        cfg_end          = '0;

        if (process)
        begin
            case (item_reg.cmd)
                CMD_TICK:
                begin
                    if (swap_reg != '0)
                    begin
                        if (front_reg)
                        begin
                            rstart_next = mem_base_reg;
                            rend_next   = wp_reg;
                            wp_next     = end_addr - WORD_BYTES;
                        end
                        else
                        begin
                            rstart_next = wp_reg + WORD_BYTES;
                            rend_next   = end_addr;
                            wp_next     = mem_base_reg;
                        end
                        front_next = !front_reg;
                        swap_next  = '0;
                    end

                    if (item_reg.rx_valid)
                    begin
                        if (item_reg.rx_data == BARRIER_WORD)
                        begin
                            bcount_next = bcount_reg + 32'd1;
                        end
                        else
                        begin
                            res.mem_write = 1'b1;
                            res.mem_addr  = wp_next;
                            res.mem_data  = item_reg.rx_data;
                            if (front_next)
                            begin
                                wp_next     = wp_next + WORD_BYTES;
                                res.overrun = (wp_next >= rstart_next);
                            end
                            else
                            begin
                                wp_next     = wp_next - WORD_BYTES;
                                res.overrun = (wp_next < rend_next);
                            end
                        end
                    end

                    case (state_reg)
                        ST_IDLE:
                        begin
                            if (bitfield_reg != '0)
                            begin
                                pending_next     = bitfield_reg;
                                id_base_next     = idbase_reg;
                                spike_index_next = '0;
                                state_next       = ST_EXTRACT;
                                bitfield_next    = '0;
                            end
                            else if (barrier_reg != '0)
                            begin
                                state_next   = ST_WAIT_BARRIER;
                                barrier_next = '0;
                            end
                        end
                        ST_EXTRACT:
                        begin
                            spike_index_next = spike_index_reg + tz;
                            if (tz >= 6'(BITFIELD_WIDTH - 1))
                            begin
                                pending_next = '0;
                            end
                            else
                            begin
                                pending_next = pending_reg >> (tz + 6'd1);
                            end
                            state_next = ST_WAIT_SPIKE;
                        end
                        ST_WAIT_SPIKE:
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_data  = id_base_reg | {26'd0, spike_index_reg};
                            if (item_reg.tx_granted)
                            begin
                                if (pending_reg == '0)
                                begin
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    spike_index_next = spike_index_reg + 6'd1;
                                    state_next       = ST_EXTRACT;
                                end
                            end
                        end
                        default:
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_data  = BARRIER_WORD;
                            if (item_reg.tx_granted)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    case (item_reg.reg_index)
                        REG_BITFIELD:
                        begin
                            res.write_dropped = (bitfield_reg != '0);
                            bitfield_next     = item_reg.reg_wdata;
                        end
                        REG_IDBASE:  idbase_next = item_reg.reg_wdata;
                        REG_BARRIER:
                        begin
                            res.write_dropped = (barrier_reg != '0);
                            barrier_next      = item_reg.reg_wdata;
                        end
                        REG_SWAP:    swap_next   = item_reg.reg_wdata;
                        REG_RSTART:  rstart_next = item_reg.reg_wdata;
                        REG_REND:    rend_next   = item_reg.reg_wdata;
                        REG_BCOUNT:  bcount_next = item_reg.reg_wdata;
                        default: ;
                    endcase
                end
                CMD_READ:
                begin
                    case (item_reg.reg_index)
                        REG_BITFIELD: res.reg_rdata = bitfield_reg;
                        REG_IDBASE:   res.reg_rdata = idbase_reg;
                        REG_BARRIER:  res.reg_rdata = barrier_reg;
                        REG_SWAP:     res.reg_rdata = swap_reg;
                        REG_RSTART:   res.reg_rdata = rstart_reg;
                        REG_REND:     res.reg_rdata = rend_reg;
                        REG_BCOUNT:   res.reg_rdata = bcount_reg;
                        default:      res.reg_rdata = '0;
                    endcase
                end
                default: ;
            endcase
        end

        if (cfg.valid)
        begin
            if (cfg.payload.addr == CFG_MEM_BASE)
            begin
                mem_base_next = cfg.payload.wdata & ADDR_MASK;
            end
            else
            begin
                mem_size_next = cfg.payload.wdata & ADDR_MASK;
            end
            cfg_end     = mem_base_next + mem_size_next;
            wp_next     = mem_base_next;
            front_next  = 1'b1;
            rstart_next = cfg_end;
            rend_next   = cfg_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            mem_base_reg     <= '0;
            mem_size_reg     <= RST_MEM_SIZE;
            state_reg        <= ST_IDLE;
            bitfield_reg     <= '0;
            idbase_reg       <= '0;
            barrier_reg      <= '0;
            swap_reg         <= '0;
            rstart_reg       <= RST_MEM_SIZE;
            rend_reg         <= RST_MEM_SIZE;
            bcount_reg       <= '0;
            pending_reg      <= '0;
            id_base_reg      <= '0;
            spike_index_reg  <= '0;
            wp_reg           <= '0;
            front_reg        <= 1'b1;
        end
        else
        begin
            if (items.ready)
            begin
                item_valid_reg <= items.valid;
            end
            result_valid_reg <= result_valid_next;
            mem_base_reg     <= mem_base_next;
            mem_size_reg     <= mem_size_next;
            state_reg        <= state_next;
            bitfield_reg     <= bitfield_next;
            idbase_reg       <= idbase_next;
            barrier_reg      <= barrier_next;
            swap_reg         <= swap_next;
            rstart_reg       <= rstart_next;
            rend_reg         <= rend_next;
            bcount_reg       <= bcount_next;
            pending_reg      <= pending_next;
            id_base_reg      <= id_base_next;
            spike_index_reg  <= spike_index_next;
            wp_reg           <= wp_next;
            front_reg        <= front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            item_reg <= items.payload;
        end
        if (process)
        begin
            result_reg <= res;
        end
    end

    `SER_ASSERT_SAME(a_extract_has_bits, state_reg == ST_EXTRACT, pending_reg != '0, "extract state entered with no pending event bits")
    `SER_ASSERT_NEXT(a_stalled_item_kept, item_valid_reg && !advance, item_valid_reg, "held item lost while results stalled")
    `SER_ASSERT_SAME(a_mem_addr_aligned, result_valid_reg && result_reg.mem_write, result_reg.mem_addr[1:0] == 2'b00, "spike memory write address not word aligned")

endmodule

// File: bench/tb_spike_event_router.sv
// ----------------------------------------------------------------------------
// tb_spike_event_router
// Self-checking bench for the spike event router. A short table of directed
// transactions covers reset values, unused commands and registers, dropped
// writes, swaps and bus retries. Random ticks, register writes and reads then
// follow under several spike memory settings. Each result is compared with a
// pinned table value or with a cycle-free model of the router in the bench.
// ----------------------------------------------------------------------------
module tb_spike_event_router;
    timeunit 1ns;
    timeprecision 1ps;

    import ser_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int REG_COUNT = 7;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MAX_WAIT = 12;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT = 2000;
    localparam result_t QUIET = '0;

    typedef enum logic [1:0] {
        M_IDLE,
        M_EXTRACT,
        M_WAIT_SPIKE,
        M_WAIT_BARRIER
    } master_e;

    typedef struct {
        logic    fixed;
        result_t val;
    } fixed_result_t;

    typedef struct {
        item_t   it;
        logic    fixed;
        result_t val;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ser_item_if   item_ch ();
    ser_result_if result_ch ();
    ser_cfg_if    cfg_ch ();

    spike_event_router u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .items   (item_ch),
        .results (result_ch)
    );

    always #2 clk = ~clk;

    // Router model state.
    logic [31:0] p_base;
    logic [31:0] p_size;
    logic [31:0] regs [REG_COUNT];
    logic [31:0] pend_bits;
    logic [31:0] p_id_base;
    logic [31:0] wptr;
    logic [5:0]  sp_idx;
    logic        fill_front;
    master_e     mst;

    result_t       expected_results [$];
    fixed_result_t pinned_results [$];
    stim_row_t     directed_rows [$];

    int mismatches = 0;
    int n_items = 0;
    int n_results = 0;
    int n_tx = 0;
    int n_memw = 0;
    int n_overrun = 0;
    int n_dropped = 0;
    int n_cfg = 0;
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;

    function automatic void reload_bufs();
        wptr = p_base;
        fill_front = 1'b1;
        regs[REG_RSTART] = p_base + p_size;
        regs[REG_REND] = p_base + p_size;
    endfunction

    function automatic void router_reset();
        p_base = '0;
        p_size = RST_MEM_SIZE;
        mst = M_IDLE;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            regs[i] = '0;
        end
        pend_bits = '0;
        p_id_base = '0;
        sp_idx = '0;
        reload_bufs();
    endfunction

    function automatic void apply_mem_cfg(cfg_t c);
        if (c.addr == CFG_MEM_BASE)
        begin
            p_base = c.wdata & ADDR_MASK;
        end
        else
        begin
            p_size = c.wdata & ADDR_MASK;
        end
        reload_bufs();
    endfunction

    function automatic logic [5:0] count_tz(logic [31:0] v);
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                return i[5:0];
            end
        end
        return 6'd32;
    endfunction

    // A received barrier marker bumps the count; any other word goes to memory.
    function automatic void store_event(item_t it, inout result_t r);
        if (!it.rx_valid)
        begin
            return;
        end
        if (it.rx_data == BARRIER_WORD)
        begin
            regs[REG_BCOUNT] = regs[REG_BCOUNT] + 32'd1;
            return;
        end
        r.mem_write = 1'b1;
        r.mem_addr = wptr;
        r.mem_data = it.rx_data;
        if (fill_front)
        begin
            wptr = wptr + WORD_BYTES;
            if (wptr >= regs[REG_RSTART])
            begin
                r.overrun = 1'b1;
            end
        end
        else
        begin
            wptr = wptr - WORD_BYTES;
            if (wptr < regs[REG_REND])
            begin
                r.overrun = 1'b1;
            end
        end
    endfunction

    function automatic void bus_tick(item_t it, inout result_t r);
        logic [5:0]  tz;
        logic [31:0] mem_end;
        if (regs[REG_SWAP] != 0)
        begin
            mem_end = p_base + p_size;
            if (fill_front)
            begin
                regs[REG_RSTART] = p_base;
                regs[REG_REND] = wptr;
                wptr = mem_end - WORD_BYTES;
            end
            else
            begin
                regs[REG_RSTART] = wptr + WORD_BYTES;
                regs[REG_REND] = mem_end;
                wptr = p_base;
            end
            fill_front = !fill_front;
            regs[REG_SWAP] = '0;
        end
        case (mst)
            M_IDLE:
            begin
                store_event(it, r);
                if (regs[REG_BITFIELD] != 0)
                begin
                    pend_bits = regs[REG_BITFIELD];
                    p_id_base = regs[REG_IDBASE];
                    sp_idx = '0;
                    mst = M_EXTRACT;
                    regs[REG_BITFIELD] = '0;
                end
                else if (regs[REG_BARRIER] != 0)
                begin
                    mst = M_WAIT_BARRIER;
                    regs[REG_BARRIER] = '0;
                end
            end
            M_EXTRACT:
            begin
                tz = count_tz(pend_bits);
                store_event(it, r);
                sp_idx = sp_idx + tz;
                pend_bits = (tz >= 6'd31) ? '0 : pend_bits >> (tz + 6'd1);
                mst = M_WAIT_SPIKE;
            end
            M_WAIT_SPIKE:
            begin
                r.tx_valid = 1'b1;
                r.tx_data = {26'd0, sp_idx} | p_id_base;
                store_event(it, r);
                if (it.tx_granted)
                begin
                    if (pend_bits == 0)
                    begin
                        mst = M_IDLE;
                    end
                    else
                    begin
                        sp_idx = sp_idx + 6'd1;
                        mst = M_EXTRACT;
                    end
                end
            end
            default:
            begin
                r.tx_valid = 1'b1;
                r.tx_data = BARRIER_WORD;
                store_event(it, r);
                if (it.tx_granted)
                begin
                    mst = M_IDLE;
                end
            end
        endcase
    endfunction

    function automatic result_t route_step(item_t it);
        result_t r;
        r = '0;
        case (it.cmd)
            CMD_TICK:
            begin
                bus_tick(it, r);
            end
            CMD_WRITE:
            begin
                if (it.reg_index != REG_NONE)
                begin
                    if ((it.reg_index == REG_BITFIELD || it.reg_index == REG_BARRIER)
                        && regs[it.reg_index] != 0)
                    begin
                        r.write_dropped = 1'b1;
                    end
                    regs[it.reg_index] = it.reg_wdata;
                end
            end
            CMD_READ:
            begin
                if (it.reg_index != REG_NONE)
                begin
                    r.reg_rdata = regs[it.reg_index];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic result_t rdata_only(logic [31:0] v);
        result_t r;
        r = '0;
        r.reg_rdata = v;
        return r;
    endfunction

    function automatic result_t drop_only();
        result_t r;
        r = '0;
        r.write_dropped = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t row(logic [1:0] cmd, logic [2:0] idx, logic [31:0] wdata,
                                      int rxv, logic [31:0] rxd, int grant,
                                      int fixed, result_t val);
        stim_row_t s;
        s.it.cmd = cmd;
        s.it.reg_index = idx;
        s.it.reg_wdata = wdata;
        s.it.rx_valid = 1'(rxv);
        s.it.rx_data = rxd;
        s.it.tx_granted = 1'(grant);
        s.fixed = 1'(fixed);
        s.val = val;
        return s;
    endfunction

    function automatic int draw_wait(logic burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int unsigned pick;
        int unsigned sel;
        it.cmd = CMD_TICK;
        it.reg_index = 3'($urandom_range(0, 7));
        it.reg_wdata = $urandom;
        it.rx_valid = 1'($urandom_range(0, 1));
        it.rx_data = ($urandom_range(0, 7) == 0) ? BARRIER_WORD : $urandom;
        it.tx_granted = ($urandom_range(0, 2) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 62)
        begin
            it.cmd = CMD_TICK;
        end
        else if (pick < 85)
        begin
            it.cmd = CMD_WRITE;
            sel = $urandom_range(0, 19);
            if (sel < 6)
            begin
                it.reg_index = REG_BITFIELD;
                if (sel % 3 == 0)
                begin
                    it.reg_wdata = 32'd1 << $urandom_range(0, 31);
                end
                else if (sel % 3 == 1)
                begin
                    it.reg_wdata = $urandom & $urandom & $urandom;
                end
            end
            else if (sel < 8)
            begin
                it.reg_index = REG_IDBASE;
                if (sel == 6)
                begin
                    it.reg_wdata = $urandom & 32'hFFFF_FFC0;
                end
            end
            else if (sel < 11)
            begin
                it.reg_index = REG_BARRIER;
            end
            else if (sel < 15)
            begin
                it.reg_index = REG_SWAP;
                if (sel == 14)
                begin
                    it.reg_wdata = '0;
                end
            end
            else if (sel == 15)
            begin
                it.reg_index = REG_RSTART;
            end
            else if (sel == 16)
            begin
                it.reg_index = REG_REND;
            end
            else if (sel == 17)
            begin
                it.reg_index = REG_BCOUNT;
            end
            else if (sel == 18)
            begin
                it.reg_index = REG_NONE;
            end
        end
        else if (pick < 97)
        begin
            it.cmd = CMD_READ;
        end
        else
        begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(item_t it, logic fixed, result_t val);
        int gap;
        fixed_result_t pin;
        if ($urandom_range(0, 31) == 0)
        begin
            tx_burst = !tx_burst;
        end
        gap = draw_wait(tx_burst);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pin.fixed = fixed;
        pin.val = val;
        pinned_results.push_back(pin);
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mem_cfg(logic [31:0] base, logic [31:0] size, logic size_first);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= size_first ? cfg_t'{addr: CFG_MEM_SIZE, wdata: size}
                                     : cfg_t'{addr: CFG_MEM_BASE, wdata: base};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.payload <= size_first ? cfg_t'{addr: CFG_MEM_BASE, wdata: base}
                                     : cfg_t'{addr: CFG_MEM_SIZE, wdata: size};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: ready is withheld for a random stall before each transaction, except in bursts.
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                rx_burst = !rx_burst;
            end
            stall = draw_wait(rx_burst);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        fixed_result_t pin;
        result_t exp_r;
        result_t got;
        if (cfg_ch.valid && cfg_ch.ready)
        begin
            apply_mem_cfg(cfg_ch.payload);
            n_cfg++;
        end
        if (item_ch.valid && item_ch.ready)
        begin
            exp_r = route_step(item_ch.payload);
            pin = pinned_results.pop_front();
            expected_results.push_back(pin.fixed ? pin.val : exp_r);
            n_items++;
        end
        if (result_ch.valid && result_ch.ready)
        begin
            got = result_ch.payload;
            n_results++;
            n_tx += int'(got.tx_valid);
            n_memw += int'(got.mem_write);
            n_overrun += int'(got.overrun);
            n_dropped += int'(got.write_dropped);
            if (expected_results.size() == 0)
            begin
                $error("result transaction arrived with nothing outstanding");
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("tx_valid", 32'(exp_r.tx_valid), 32'(got.tx_valid));
                check_field("tx_data", exp_r.tx_data, got.tx_data);
                check_field("mem_write", 32'(exp_r.mem_write), 32'(got.mem_write));
                check_field("mem_addr", exp_r.mem_addr, got.mem_addr);
                check_field("mem_data", exp_r.mem_data, got.mem_data);
                check_field("reg_rdata", exp_r.reg_rdata, got.reg_rdata);
                check_field("overrun", 32'(exp_r.overrun), 32'(got.overrun));
                check_field("write_dropped", 32'(exp_r.write_dropped),
                            32'(got.write_dropped));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        do
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        while (idle_cycles < STALL_LIMIT);
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [31:0] phase_base [PHASES];
        logic [31:0] phase_size [PHASES];
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.payload <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.payload <= '0;
        router_reset();

        phase_base[1] = 32'h0000_1003;
        phase_size[1] = 32'd64;
        phase_base[2] = 32'hFFFF_FFFC;
        phase_size[2] = 32'd8;
        phase_base[3] = 32'h0000_0000;
        phase_size[3] = 32'hFFFF_FFFF;
        phase_base[4] = $urandom;
        phase_size[4] = {30'($urandom_range(2, 40)), 2'b11};

        directed_rows.push_back(row(CMD_READ, REG_RSTART, '0, 0, '0, 0, 1,
                                    rdata_only(RST_MEM_SIZE)));
        directed_rows.push_back(row(CMD_READ, REG_REND, '0, 0, '0, 0, 1,
                                    rdata_only(RST_MEM_SIZE)));
        directed_rows.push_back(row(CMD_READ, REG_BCOUNT, '0, 0, '0, 0, 1, QUIET));
        directed_rows.push_back(row(CMD_UNUSED, REG_NONE, 32'hFFFF_FFFF, 1, BARRIER_WORD, 1,
                                    1, QUIET));
        directed_rows.push_back(row(CMD_READ, REG_NONE, '0, 0, '0, 0, 1, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_NONE, 32'hFFFF_FFFF, 0, '0, 0, 1, QUIET));
        directed_rows.push_back(row(CMD_TICK, REG_BITFIELD, '0, 0, '0, 1, 1, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_BITFIELD, 32'h8000_0001, 0, '0, 0, 1, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_BITFIELD, 32'hFFFF_FFFF, 0, '0, 0, 1,
                                    drop_only()));
        directed_rows.push_back(row(CMD_WRITE, REG_IDBASE, 32'hFFFF_FFC0, 0, '0, 0, 1, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_BARRIER, 32'd1, 0, '0, 0, 1, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_BARRIER, '0, 0, '0, 0, 1, drop_only()));
        directed_rows.push_back(row(CMD_TICK, REG_BITFIELD, '0, 1, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_TICK, REG_BITFIELD, '0, 1, BARRIER_WORD, 1, 0, QUIET));
        directed_rows.push_back(row(CMD_TICK, REG_BITFIELD, '0, 1, 32'h1234_5678, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_TICK, REG_BITFIELD, '0, 0, '0, 1, 0, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_SWAP, 32'd1, 0, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_TICK, REG_BITFIELD, '0, 1, 32'hFFFF_FFFE, 1, 0, QUIET));
        directed_rows.push_back(row(CMD_READ, REG_RSTART, '0, 0, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_READ, REG_REND, '0, 0, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_READ, REG_BCOUNT, '0, 0, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_BARRIER, 32'hFFFF_FFFF, 0, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_RSTART, 32'hFFFF_FFFF, 0, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_REND, '0, 0, '0, 0, 0, QUIET));
        directed_rows.push_back(row(CMD_WRITE, REG_BCOUNT, 32'hFFFF_FFFF, 0, '0, 0, 0, QUIET));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].val);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_drained();
                write_mem_cfg(phase_base[ph], phase_size[ph], ph[0]);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Let the pipeline run dry once per phase.
                if (n == ITEMS_PER_PHASE / 2)
                begin
                    wait_drained();
                end
                send_item(rand_item(), 1'b0, QUIET);
            end
        end
        wait_drained();
        repeat (2 * MAX_WAIT) @(posedge clk);

        $display("Ran %0d items over %0d memory settings with %0d configuration writes.",
                 n_items, PHASES, n_cfg);
        $display("Saw %0d bus words, %0d memory writes, %0d overruns, %0d dropped writes.",
                 n_tx, n_memw, n_overrun, n_dropped);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
